/* hw/rtl/rsci_pkg.sv */
package rsci_pkg;

   localparam int MAX_TOTAL_DEF = 32;
   localparam int COUNT_W = 30;
   localparam int CUM_W = 32;
   localparam int GOAL_W = 46;

   // side codes
   localparam logic [1:0] SIDE_TWO      = 2'd0;
   localparam logic [1:0] SIDE_LOW_OPEN = 2'd1;
   localparam logic [1:0] SIDE_UP_OPEN  = 2'd2;

   // histogram write select
   localparam logic [1:0] WR_ZERO = 2'd0;
   localparam logic [1:0] WR_ONE  = 2'd1;
   localparam logic [1:0] WR_ADD  = 2'd2;
   localparam logic [1:0] WR_SUB  = 2'd3;

   typedef struct packed {
      logic [4:0]  x_count;
      logic [4:0]  y_count;
      logic [15:0] alpha_q16;
      logic [1:0]  side;
   } req_type;

   typedef struct packed {
      logic [9:0] lower_bound;
      logic [9:0] upper_bound;
      logic       lower_open;
      logic       upper_open;
      logic [9:0] expected_sum_x2;
      logic       size_error;
   } rsp_type;

   typedef struct packed {
      logic       load_query;
      logic       clr_acc;
      logic       acc_total;
      logic       acc_tail;
      logic       calc_goal;
      logic       load_result;
      logic       wr_en;
      logic [1:0] wr_sel;
   } cmd_type;

   typedef struct packed {
      logic       size_bad;
      logic       tail_more;
      logic       rsp_free;
      logic [4:0] x_count;
      logic [4:0] y_count;
   } status_type;

endpackage

/* hw/rtl/rsci_ram.sv */
module rsci_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 257,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

/* hw/rtl/rsci_datapath.sv */
module rsci_datapath #(
   parameter int MAX_TOTAL = rsci_pkg::MAX_TOTAL_DEF,
   localparam int HIST_DEPTH = (MAX_TOTAL * MAX_TOTAL) / 4 + 1,
   localparam int ADDR_W = $clog2(HIST_DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rsci_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsci_pkg::rsp_type    rsp_data,
   input  rsci_pkg::cmd_type    cmd,
   input  logic [ADDR_W-1:0]    rd_addr_a,
   input  logic [ADDR_W-1:0]    rd_addr_b,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [ADDR_W:0]      steps,
   output rsci_pkg::status_type status,
   output logic [ADDR_W-1:0]    span
);
   import rsci_pkg::*;

   req_type             q_ff;
   logic [COUNT_W-1:0]  total_ff, total_in;
   logic [CUM_W-1:0]    cum_ff, cum_in;
   logic [GOAL_W-1:0]   goal_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff;
   logic [COUNT_W-1:0]  rd_data_a, rd_data_b, wr_data;
   logic [9:0]          smin, span_full, smax;
   logic                size_bad;
   rsp_type             rsp_in;

   rsci_ram #(.WIDTH(COUNT_W), .DEPTH(HIST_DEPTH)) u_hist (
      .clock     (clock),
      .wr_en     (cmd.wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // in-place polynomial update, wraps modulo 2^COUNT_W
   always_comb begin
      unique case (cmd.wr_sel)
         WR_ZERO: wr_data = '0;
         WR_ONE:  wr_data = COUNT_W'(1);
         WR_ADD:  wr_data = rd_data_a + rd_data_b;
         WR_SUB:  wr_data = rd_data_a - rd_data_b;
         default: wr_data = '0;
      endcase
   end

   assign smin      = 10'((10'(q_ff.x_count) * (10'(q_ff.x_count) + 10'd1)) >> 1);
   assign span_full = 10'(q_ff.x_count) * 10'(q_ff.y_count);
   assign smax      = smin + span_full;
   assign span      = ADDR_W'(span_full);
   assign size_bad  = (q_ff.x_count == 5'd0) || (q_ff.y_count == 5'd0) ||
                      ((7'(q_ff.x_count) + 7'(q_ff.y_count)) > 7'(MAX_TOTAL));

   always_comb begin
      rsp_in = '0;
      if (size_bad) begin
         rsp_in.size_error = 1'b1;
      end else begin
         rsp_in.lower_open = (q_ff.side == SIDE_LOW_OPEN);
         rsp_in.upper_open = (q_ff.side == SIDE_UP_OPEN);
         if (q_ff.side != SIDE_LOW_OPEN) begin
            rsp_in.lower_bound = smin + 10'(steps) - 10'd1;
         end
         if (q_ff.side != SIDE_UP_OPEN) begin
            rsp_in.upper_bound = smax + 10'd1 - 10'(steps);
         end
         rsp_in.expected_sum_x2 = 10'(q_ff.x_count) *
                                  (10'(q_ff.x_count) + 10'(q_ff.y_count) + 10'd1);
      end
   end

   always_comb begin
      total_in = total_ff;
      cum_in   = cum_ff;
      if (cmd.clr_acc) begin
         total_in = '0;
         cum_in   = '0;
      end else if (cmd.acc_total) begin
         total_in = total_ff + rd_data_a;
      end else if (cmd.acc_tail) begin
         priority if (q_ff.side == SIDE_LOW_OPEN) begin
            cum_in = cum_ff + CUM_W'(rd_data_b);
         end else if (q_ff.side == SIDE_UP_OPEN) begin
            cum_in = cum_ff + CUM_W'(rd_data_a);
         end else begin
            cum_in = cum_ff + CUM_W'(rd_data_a) + CUM_W'(rd_data_b);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         q_ff <= req_data;
      end
      total_ff <= total_in;
      cum_ff   <= cum_in;
      if (cmd.calc_goal) begin
         goal_ff <= GOAL_W'(q_ff.alpha_q16) * GOAL_W'(total_ff);
      end
      if (cmd.load_result) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status.size_bad  = size_bad;
   assign status.tail_more = {cum_ff, 16'd0} < (CUM_W + 16)'(goal_ff);
   assign status.rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign status.x_count   = q_ff.x_count;
   assign status.y_count   = q_ff.y_count;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded over a pending transaction");

endmodule

/* hw/rtl/rsci_ctrl.sv */
module rsci_ctrl #(
   parameter int MAX_TOTAL = rsci_pkg::MAX_TOTAL_DEF,
   localparam int HIST_DEPTH = (MAX_TOTAL * MAX_TOTAL) / 4 + 1,
   localparam int ADDR_W = $clog2(HIST_DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rsci_pkg::status_type status,
   input  logic [ADDR_W-1:0]    span,
   output rsci_pkg::cmd_type    cmd,
   output logic [ADDR_W-1:0]    rd_addr_a,
   output logic [ADDR_W-1:0]    rd_addr_b,
   output logic [ADDR_W-1:0]    wr_addr,
   output logic [ADDR_W:0]      steps
);
   import rsci_pkg::*;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_SIZE     = 4'd1;
   localparam logic [3:0] ST_INIT     = 4'd2;
   localparam logic [3:0] ST_DIV_RD   = 4'd3;
   localparam logic [3:0] ST_DIV_WR   = 4'd4;
   localparam logic [3:0] ST_MUL_RD   = 4'd5;
   localparam logic [3:0] ST_MUL_WR   = 4'd6;
   localparam logic [3:0] ST_NEXT     = 4'd7;
   localparam logic [3:0] ST_SUM_RD   = 4'd8;
   localparam logic [3:0] ST_SUM_ACC  = 4'd9;
   localparam logic [3:0] ST_GOAL     = 4'd10;
   localparam logic [3:0] ST_TAIL_CHK = 4'd11;
   localparam logic [3:0] ST_TAIL_ADD = 4'd12;
   localparam logic [3:0] ST_DONE     = 4'd13;

   logic [3:0]        state_ff, state_in;
   logic [ADDR_W-1:0] t_ff, t_in;
   logic [4:0]        i_ff, i_in;
   logic [ADDR_W:0]   steps_ff, steps_in;
   logic [5:0]        nsum;
   logic              mul_skip;
   logic              t_at_span;

   // multiply pass shifts by n+i
   assign nsum      = 6'(status.y_count) + 6'(i_ff);
   assign mul_skip  = 10'(nsum) > 10'(span);
   assign t_at_span = (t_ff == span);

   always_comb begin
      state_in  = state_ff;
      t_in      = t_ff;
      i_in      = i_ff;
      steps_in  = steps_ff;
      cmd       = '0;
      req_stall = 1'b1;
      wr_addr   = t_ff;
      rd_addr_a = t_ff;
      rd_addr_b = t_ff - ADDR_W'(i_ff);
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_query = 1'b1;
               state_in       = ST_SIZE;
            end
         end
         ST_SIZE: begin
            cmd.clr_acc = 1'b1;
            t_in        = '0;
            state_in    = status.size_bad ? ST_DONE : ST_INIT;
         end
         ST_INIT: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = (t_ff == '0) ? WR_ONE : WR_ZERO;
            if (t_at_span) begin
               i_in     = 5'd1;
               t_in     = ADDR_W'(1);
               state_in = ST_DIV_RD;
            end else begin
               t_in = t_ff + ADDR_W'(1);
            end
         end
         ST_DIV_RD: begin
            state_in = ST_DIV_WR;
         end
         ST_DIV_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_ADD;
            if (t_at_span) begin
               if (mul_skip) begin
                  state_in = ST_NEXT;
               end else begin
                  t_in     = span;
                  state_in = ST_MUL_RD;
               end
            end else begin
               t_in     = t_ff + ADDR_W'(1);
               state_in = ST_DIV_RD;
            end
         end
         ST_MUL_RD: begin
            rd_addr_b = t_ff - ADDR_W'(nsum);
            state_in  = ST_MUL_WR;
         end
         ST_MUL_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_SUB;
            if (10'(t_ff) == 10'(nsum)) begin
               state_in = ST_NEXT;
            end else begin
               t_in     = t_ff - ADDR_W'(1);
               state_in = ST_MUL_RD;
            end
         end
         ST_NEXT: begin
            if (i_ff == status.x_count) begin
               t_in     = '0;
               state_in = ST_SUM_RD;
            end else begin
               i_in     = i_ff + 5'd1;
               t_in     = ADDR_W'(i_ff) + ADDR_W'(1);
               state_in = ST_DIV_RD;
            end
         end
         ST_SUM_RD: begin
            state_in = ST_SUM_ACC;
         end
         ST_SUM_ACC: begin
            cmd.acc_total = 1'b1;
            if (t_at_span) begin
               state_in = ST_GOAL;
            end else begin
               t_in     = t_ff + ADDR_W'(1);
               state_in = ST_SUM_RD;
            end
         end
         ST_GOAL: begin
            cmd.calc_goal = 1'b1;
            steps_in      = '0;
            state_in      = ST_TAIL_CHK;
         end
         ST_TAIL_CHK: begin
            rd_addr_a = steps_ff[ADDR_W-1:0];
            rd_addr_b = span - steps_ff[ADDR_W-1:0];
            if ((steps_ff <= {1'b0, span}) && status.tail_more) begin
               state_in = ST_TAIL_ADD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_TAIL_ADD: begin
            cmd.acc_tail = 1'b1;
            steps_in     = steps_ff + (ADDR_W + 1)'(1);
            state_in     = ST_TAIL_CHK;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.load_result = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff     <= t_in;
      i_ff     <= i_in;
      steps_ff <= steps_in;
   end

   assign steps = steps_ff;

   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> (wr_addr <= span))
      else $error("histogram write past span");

   a_steps_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TAIL_CHK || state_ff == ST_TAIL_ADD) |->
      (steps_ff <= ({1'b0, span} + (ADDR_W + 1)'(1))))
      else $error("tail steps past span");

   a_tail_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TAIL_ADD) |-> ($past(state_ff) == ST_TAIL_CHK))
      else $error("tail add without check");

endmodule

/* hw/rtl/rank_sum_critical_interval.sv */
// Exact rank-sum critical interval.
// req channel: one transaction per query (sizes m, n, alpha in Q0.16, side).
// rsp channel: one transaction per query with interval bounds, open-end
// flags, m*(m+n+1) and a size error flag.
// Both channels use valid/stall; a transaction moves when valid is high and
// stall is low.
// A size error goes straight from the size check to the result load. Otherwise
// the histogram (coefficients of the Gaussian binomial) is built in place in
// one RAM by m divide passes and up to m multiply passes, each touched entry
// read and then written, then summed entry by entry and walked from the tails.
// One query is processed at a time; req_stall is high from acceptance until
// the result is handed to the output register.
// A finished result waits in the output register while the next query is
// accepted; a new result is loaded only once the previous one is taken.
// Reset (synchronous) clears the controller and the output valid. The RAM
// needs no clearing pass: each query rewrites entries 0..m*n first.
module rank_sum_critical_interval #(
   parameter int MAX_TOTAL = rsci_pkg::MAX_TOTAL_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rsci_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsci_pkg::rsp_type rsp_data
);
   import rsci_pkg::*;

   localparam int HIST_DEPTH = (MAX_TOTAL * MAX_TOTAL) / 4 + 1;
   localparam int ADDR_W = $clog2(HIST_DEPTH);

   cmd_type           cmd;
   status_type        status;
   logic [ADDR_W-1:0] span;
   logic [ADDR_W-1:0] rd_addr_a, rd_addr_b, wr_addr;
   logic [ADDR_W:0]   steps;

   // sequencing: init, polynomial passes, total, tail walk, result load
   rsci_ctrl #(.MAX_TOTAL(MAX_TOTAL)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .span      (span),
      .cmd       (cmd),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .wr_addr   (wr_addr),
      .steps     (steps)
   );

   // histogram RAM, accumulators, goal multiply, output register
   rsci_datapath #(.MAX_TOTAL(MAX_TOTAL)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .wr_addr   (wr_addr),
      .steps     (steps),
      .status    (status),
      .span      (span)
   );

endmodule

/* test/tb_top.sv */
module tb_top;
   import rsci_pkg::*;

   // side code 3 is not named in the package; the block treats it as two-sided
   localparam logic [1:0] SIDE_ALT_TWO = 2'd3;
   localparam int MAX_SIZE = 32;
   localparam int SUM_TOP = (MAX_SIZE * (MAX_SIZE + 1)) / 2;
   localparam int IDLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 3000;
   localparam int DRAIN_CYCLES = 100;

   // idle profiles
   localparam int MODE_SEND_LIGHT = 0;  // sender 11%, receiver 66%
   localparam int MODE_RECV_LIGHT = 1;  // sender 66%, receiver 11%
   localparam int MODE_NO_IDLE    = 2;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   rsp_type interval_q[$];   // predicted intervals, oldest first
   int      errors = 0;
   int      idle_mode = MODE_SEND_LIGHT;
   int      hold_len = 0;    // request for a long receiver hold-off
   int      hold_cnt = 0;
   int      idle_cycles = 0;

   // subset counts: ways[k][s] = number of k-subsets of ranks with sum s
   longint  ways[0:MAX_SIZE][0:SUM_TOP];

   rank_sum_critical_interval dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predict the interval for one query
   function automatic rsp_type interval_of(req_type q);
      int m, n, tot, span, smin, smax, steps, e, k, s, kmax, shigh;
      longint total, cum, goal, lo, hi;
      rsp_type r;
      r = '0;
      m = q.x_count;
      n = q.y_count;
      if (m == 0 || n == 0 || m + n > MAX_SIZE) begin
         r.size_error = 1'b1;
         return r;
      end
      tot = m + n;
      for (k = 0; k <= MAX_SIZE; k++)
         for (s = 0; s <= SUM_TOP; s++)
            ways[k][s] = 0;
      ways[0][0] = 1;
      // add ranks one by one, sizes downward so each rank is used once
      for (e = 1; e <= tot; e++) begin
         kmax = (e < m) ? e : m;
         shigh = (e * (e + 1)) / 2;
         for (k = kmax; k >= 1; k--)
            for (s = shigh; s >= e; s--)
               ways[k][s] += ways[k-1][s-e];
      end
      smin = (m * (m + 1)) / 2;
      span = m * n;
      smax = smin + span;
      total = 0;
      for (s = 0; s <= span; s++) begin
         ways[m][smin+s] &= 64'h3FFF_FFFF;
         total += ways[m][smin+s];
      end
      goal = longint'(q.alpha_q16) * total;
      cum = 0;
      steps = 0;
      // walk in from the tails until the tail share reaches alpha
      while (cum * 65536 < goal && steps <= span) begin
         lo = ways[m][smin+steps];
         hi = ways[m][smin+span-steps];
         if (q.side == SIDE_LOW_OPEN)
            cum += hi;
         else if (q.side == SIDE_UP_OPEN)
            cum += lo;
         else
            cum += lo + hi;
         steps++;
      end
      if (q.side == SIDE_LOW_OPEN)
         r.lower_open = 1'b1;
      else
         r.lower_bound = 10'(smin + steps - 1);
      if (q.side == SIDE_UP_OPEN)
         r.upper_open = 1'b1;
      else
         r.upper_bound = 10'(smax + 1 - steps);
      r.expected_sum_x2 = 10'(m * (tot + 1));
      return r;
   endfunction

   function automatic int field_bad(string name, int want, int got);
      if (want != got) begin
         $display("%0t: mismatch %s expected %0d actual %0d", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // Result side: checks, receiver stall, watchdog
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (interval_q.size() == 0) begin
               $display("%0t: unexpected result transaction %h", $time, rsp_data);
               errors++;
            end else begin
               want = interval_q.pop_front();
               errors += field_bad("lower_bound", want.lower_bound, rsp_data.lower_bound);
               errors += field_bad("upper_bound", want.upper_bound, rsp_data.upper_bound);
               errors += field_bad("lower_open", want.lower_open, rsp_data.lower_open);
               errors += field_bad("upper_open", want.upper_open, rsp_data.upper_open);
               errors += field_bad("expected_sum_x2", want.expected_sum_x2,
                                   rsp_data.expected_sum_x2);
               errors += field_bad("size_error", want.size_error, rsp_data.size_error);
            end
         end
         // watchdog: cycles with no transaction on either channel
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
      if (hold_len > 0) begin
         hold_cnt = hold_len;
         hold_len = 0;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_stall <= 1'b1;
      end else if (idle_mode == MODE_SEND_LIGHT)
         rsp_stall <= ($urandom_range(99) < 66);
      else if (idle_mode == MODE_RECV_LIGHT)
         rsp_stall <= ($urandom_range(99) < 11);
      else
         rsp_stall <= 1'b0;
   end

   // Offer one query; returns at the edge where it is accepted, valid left high
   task automatic send_query(input req_type q);
      int pct;
      pct = (idle_mode == MODE_SEND_LIGHT) ? 11 : (idle_mode == MODE_RECV_LIGHT) ? 66 : 0;
      while ($urandom_range(99) < pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      interval_q.push_back(interval_of(q));
   endtask

   task automatic send_fields(input int m, input int n, input int a, input int sd);
      req_type q;
      q.x_count = 5'(m);
      q.y_count = 5'(n);
      q.alpha_q16 = 16'(a);
      q.side = 2'(sd);
      send_query(q);
   endtask

   task automatic wait_empty();
      req_valid <= 1'b0;
      @(posedge clock);
      while (interval_q.size() != 0) @(posedge clock);
   endtask

   // field extremes, every side, zero and full alpha, m=1 and n=1
   task automatic test_directed();
      send_fields(1, 1, 0, SIDE_TWO);
      send_fields(1, 1, 16'hFFFF, SIDE_TWO);
      send_fields(1, 31, 3277, SIDE_TWO);
      send_fields(31, 1, 3277, SIDE_LOW_OPEN);
      send_fields(31, 1, 16'hFFFF, SIDE_UP_OPEN);
      send_fields(3, 4, 3277, SIDE_LOW_OPEN);
      send_fields(3, 4, 3277, SIDE_UP_OPEN);
      send_fields(3, 4, 3277, SIDE_ALT_TWO);
      send_fields(5, 5, 16'hFFFF, SIDE_TWO);     // bounds cross past the middle
      send_fields(5, 5, 16'hAAAA, SIDE_ALT_TWO);
      send_fields(4, 6, 16'h5555, SIDE_UP_OPEN);
      send_fields(16, 16, 3277, SIDE_TWO);
      send_fields(2, 30, 0, SIDE_LOW_OPEN);
      send_fields(6, 2, 1, SIDE_TWO);
   endtask

   // zero sizes and sums past the maximum
   task automatic test_size_error();
      send_fields(0, 5, 3277, SIDE_TWO);
      send_fields(5, 0, 3277, SIDE_LOW_OPEN);
      send_fields(0, 0, 0, SIDE_UP_OPEN);
      send_fields(31, 31, 16'hFFFF, SIDE_ALT_TWO);
      send_fields(17, 16, 100, SIDE_TWO);
   endtask

   // receiver holds off while queries keep coming, so the input stalls
   task automatic test_backpressure();
      int i;
      hold_len = HOLD_CYCLES;
      for (i = 0; i < 5; i++)
         send_fields($urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(65535),
                     $urandom_range(3));
      wait_empty();
   endtask

   task automatic test_random(input int count);
      int i, m, n, pick, a;
      for (i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            m = $urandom_range(0, 31);
            n = $urandom_range(0, 31);
            if (m != 0 && n != 0 && m + n <= MAX_SIZE) m = 0;
         end else if (pick < 16) begin
            m = $urandom_range(1, 31);
            n = $urandom_range(1, MAX_SIZE - m);
         end else begin
            m = $urandom_range(1, 8);
            n = $urandom_range(1, 8);
         end
         pick = $urandom_range(9);
         a = (pick == 0) ? 0 : (pick == 1) ? 65535 : (pick < 5) ? $urandom_range(6554)
             : $urandom_range(65535);
         send_fields(m, n, a, $urandom_range(3));
         if (i == count / 2) wait_empty();   // sender pause until all results are in
      end
   endtask

   initial begin
      int i;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      idle_mode = MODE_SEND_LIGHT;
      test_directed();
      test_size_error();
      test_backpressure();
      test_random(35);
      idle_mode = MODE_RECV_LIGHT;
      test_random(35);
      idle_mode = MODE_NO_IDLE;
      test_random(30);
      wait_empty();
      for (i = 0; i < DRAIN_CYCLES; i++) @(posedge clock);
      if (errors == 0 && interval_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
